>>> hdl/csbm_pkg.sv
// ----------------------------------------------------------------------------
// csbm_pkg
// Shared constants, codes and controller/datapath interface types for the
// clock-sweep buffer manager.
// ----------------------------------------------------------------------------
package csbm_pkg;

    localparam int SLOTS     = 16;
    localparam int USAGE_MAX = 15;

    localparam int PAGE_W  = 64;
    localparam int CFG_W   = 5;
    localparam int SLOT_W  = $clog2(SLOTS);
    localparam int CNT_W   = $clog2(SLOTS + 1);
    localparam int USAGE_W = $clog2(USAGE_MAX + 1);
    localparam int VISIT_W = $clog2((USAGE_MAX + 1) * SLOTS + 1);
    localparam int IDX_W   = 4;
    localparam int STAT_W  = 2;
    localparam int ODATA_W = 8;

    localparam logic [STAT_W-1:0] ST_HIT    = 2'd0;
    localparam logic [STAT_W-1:0] ST_MISS   = 2'd1;
    localparam logic [STAT_W-1:0] ST_NOFREE = 2'd2;
    localparam logic [STAT_W-1:0] ST_ABSENT = 2'd3;

    localparam logic CMD_REQUEST = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_CMP  = 5'b00010,
        S_DEC  = 5'b00100,
        S_SWP  = 5'b01000,
        S_RES  = 5'b10000
    } t_state;

    typedef struct packed {
        logic load;
        logic compare;
        logic decide;
        logic step;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic go_sweep;
        logic sweep_done;
        logic out_free;
    } t_dp_stat;

endpackage

>>> hdl/csbm_cfg.sv
// ----------------------------------------------------------------------------
// csbm_cfg
// APB register block holding the active slot count, with the clamped count
// handed to the datapath.
// ----------------------------------------------------------------------------
module csbm_cfg (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [2:0]               paddr,
    input  logic [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready,
    output logic [csbm_pkg::CNT_W-1:0] o_active
);

    logic [csbm_pkg::CFG_W-1:0] r_active;
    logic                       w_wr;

    assign w_wr   = psel && penable && pwrite && !paddr[2];
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= csbm_pkg::CFG_W'(16);
        end else if (w_wr) begin
            r_active <= pwdata[csbm_pkg::CFG_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (!paddr[2]) begin
            prdata = {{(32 - csbm_pkg::CFG_W){1'b0}}, r_active};
        end
    end

    always_comb begin
        if (r_active == '0) begin
            o_active = csbm_pkg::CNT_W'(1);
        end else if (int'(r_active) > csbm_pkg::SLOTS) begin
            o_active = csbm_pkg::CNT_W'(csbm_pkg::SLOTS);
        end else begin
            o_active = csbm_pkg::CNT_W'(r_active);
        end
    end

endmodule

>>> hdl/csbm_ctrl.sv
// ----------------------------------------------------------------------------
// csbm_ctrl
// Sequencer: accept, compare tags, decide hit or sweep, walk the clock hand,
// hand the result to the output register.
// ----------------------------------------------------------------------------
module csbm_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  csbm_pkg::t_dp_stat i_stat,
    output csbm_pkg::t_dp_cmd  o_cmd
);

    csbm_pkg::t_state r_state;
    csbm_pkg::t_state n_state;

    assign o_in_ready = (r_state == csbm_pkg::S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= csbm_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            csbm_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = csbm_pkg::S_CMP;
                end
            end
            csbm_pkg::S_CMP: begin
                o_cmd.compare = 1'b1;
                n_state       = csbm_pkg::S_DEC;
            end
            csbm_pkg::S_DEC: begin
                o_cmd.decide = 1'b1;
                n_state      = i_stat.go_sweep ? csbm_pkg::S_SWP : csbm_pkg::S_RES;
            end
            csbm_pkg::S_SWP: begin
                o_cmd.step = 1'b1;
                if (i_stat.sweep_done) begin
                    n_state = csbm_pkg::S_RES;
                end
            end
            csbm_pkg::S_RES: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = csbm_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = csbm_pkg::S_IDLE;
            end
        endcase
    end

endmodule

>>> hdl/csbm_dpath.sv
// ----------------------------------------------------------------------------
// csbm_dpath
// Slot state, tag compare, hit update, clock-hand sweep and output register.
// ----------------------------------------------------------------------------
module csbm_dpath (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  csbm_pkg::t_dp_cmd                 i_cmd,
    output csbm_pkg::t_dp_stat                o_stat,
    input  logic [csbm_pkg::CNT_W-1:0]        i_active,
    input  logic                              i_in_cmd,
    input  logic [csbm_pkg::PAGE_W-1:0]       i_in_page,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [csbm_pkg::ODATA_W-1:0]      o_out_data
);

    logic                               r_cmd;
    logic [csbm_pkg::PAGE_W-1:0]        r_page;
    logic [csbm_pkg::SLOTS-1:0]         r_match;
    logic [csbm_pkg::PAGE_W-1:0]        r_tag   [csbm_pkg::SLOTS];
    logic [csbm_pkg::SLOTS-1:0]         r_valid;
    logic [csbm_pkg::SLOTS-1:0]         r_pinned;
    logic [csbm_pkg::USAGE_W-1:0]       r_usage [csbm_pkg::SLOTS];
    logic [csbm_pkg::SLOT_W-1:0]        r_hand;
    logic [csbm_pkg::VISIT_W-1:0]       r_visits;
    logic [csbm_pkg::IDX_W-1:0]         r_res_slot;
    logic [csbm_pkg::STAT_W-1:0]        r_res_status;
    logic                               r_res_rd;
    logic                               r_ovalid;
    logic [csbm_pkg::ODATA_W-1:0]       r_odata;

    logic [csbm_pkg::SLOTS-1:0]         w_sel;
    logic                               w_hit;
    logic [csbm_pkg::SLOT_W-1:0]        w_hit_idx;
    logic [csbm_pkg::VISIT_W-1:0]       w_limit;
    logic                               w_last;
    logic                               w_take;
    logic [csbm_pkg::USAGE_W-1:0]       w_hand_usage;
    logic [csbm_pkg::SLOT_W-1:0]        w_hand_next;
    logic                               w_out_free;

    assign w_sel = r_match & ~(r_match - csbm_pkg::SLOTS'(1));
    assign w_hit = |r_match;

    always_comb begin
        w_hit_idx = '0;
        for (int i = 0; i < csbm_pkg::SLOTS; i++) begin
            if (w_sel[i]) begin
                w_hit_idx = csbm_pkg::SLOT_W'(i);
            end
        end
    end

    assign w_limit      = csbm_pkg::VISIT_W'(i_active)
                        * csbm_pkg::VISIT_W'(csbm_pkg::USAGE_MAX + 1);
    assign w_last       = (r_visits == w_limit - csbm_pkg::VISIT_W'(1));
    assign w_hand_usage = r_usage[r_hand];
    assign w_take       = !r_pinned[r_hand] && (w_hand_usage == '0);
    assign w_hand_next  = (csbm_pkg::CNT_W'(r_hand) + csbm_pkg::CNT_W'(1) == i_active)
                        ? '0 : r_hand + csbm_pkg::SLOT_W'(1);
    assign w_out_free   = !r_ovalid || i_out_ready;

    assign o_stat.go_sweep   = (r_cmd == csbm_pkg::CMD_REQUEST) && !w_hit;
    assign o_stat.sweep_done = w_take || w_last;
    assign o_stat.out_free   = w_out_free;

    // request and tag compare
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd  <= i_in_cmd;
            r_page <= i_in_page;
        end
        if (i_cmd.compare) begin
            for (int i = 0; i < csbm_pkg::SLOTS; i++) begin
                r_match[i] <= r_valid[i] && (csbm_pkg::CNT_W'(i) < i_active)
                            && (r_tag[i] == r_page);
            end
        end
    end

    // tags
    always_ff @(posedge i_clk) begin
        if (i_cmd.step && w_take) begin
            r_tag[r_hand] <= r_page;
        end
    end

    // slot control state and hand
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_pinned <= '0;
            r_hand   <= '0;
            r_visits <= '0;
            for (int i = 0; i < csbm_pkg::SLOTS; i++) begin
                r_usage[i] <= '0;
            end
        end else if (i_cmd.decide) begin
            if (r_cmd == csbm_pkg::CMD_RELEASE) begin
                for (int i = 0; i < csbm_pkg::SLOTS; i++) begin
                    if (w_sel[i]) begin
                        r_pinned[i] <= 1'b0;
                    end
                end
            end else if (w_hit) begin
                for (int i = 0; i < csbm_pkg::SLOTS; i++) begin
                    if (w_sel[i]) begin
                        r_pinned[i] <= 1'b1;
                        if (int'(r_usage[i]) < csbm_pkg::USAGE_MAX) begin
                            r_usage[i] <= r_usage[i] + csbm_pkg::USAGE_W'(1);
                        end else begin
                            r_usage[i] <= csbm_pkg::USAGE_W'(csbm_pkg::USAGE_MAX);
                        end
                    end
                end
            end else begin
                r_visits <= '0;
                if (csbm_pkg::CNT_W'(r_hand) >= i_active) begin
                    r_hand <= '0;
                end
            end
        end else if (i_cmd.step) begin
            r_hand   <= w_hand_next;
            r_visits <= r_visits + csbm_pkg::VISIT_W'(1);
            if (w_take) begin
                r_valid[r_hand]  <= 1'b1;
                r_pinned[r_hand] <= 1'b1;
                r_usage[r_hand]  <= csbm_pkg::USAGE_W'(1);
            end else if (w_hand_usage != '0) begin
                r_usage[r_hand] <= w_hand_usage - csbm_pkg::USAGE_W'(1);
            end
        end
    end

    // result
    always_ff @(posedge i_clk) begin
        if (i_cmd.decide) begin
            r_res_rd <= 1'b0;
            if (w_hit) begin
                r_res_slot   <= csbm_pkg::IDX_W'(w_hit_idx);
                r_res_status <= csbm_pkg::ST_HIT;
            end else begin
                r_res_slot   <= '0;
                r_res_status <= csbm_pkg::ST_ABSENT;
            end
        end else if (i_cmd.step) begin
            if (w_take) begin
                r_res_slot   <= csbm_pkg::IDX_W'(r_hand);
                r_res_status <= csbm_pkg::ST_MISS;
                r_res_rd     <= 1'b1;
            end else if (w_last) begin
                r_res_slot   <= '0;
                r_res_status <= csbm_pkg::ST_NOFREE;
                r_res_rd     <= 1'b0;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_odata <= {1'b0, r_res_rd, r_res_status, r_res_slot};
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_odata;

endmodule

>>> hdl/clock_sweep_buffer_manager.sv
// ----------------------------------------------------------------------------
// clock_sweep_buffer_manager
// Buffer pool slot manager with clock-sweep replacement.
// ----------------------------------------------------------------------------
// One item is processed at a time. A release or a request that hits goes
// through accept, tag compare, decide and hand-off before its result enters
// the output register. A request that misses sweeps the clock hand between
// decide and hand-off, one slot visit per cycle; when every active slot
// stays pinned the sweep runs 16 x active-count visits before reporting no
// free slot. The next item is accepted as soon as the result has moved to
// the output register, even if the sink has not taken it yet.
// ----------------------------------------------------------------------------
module clock_sweep_buffer_manager (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // slave stream
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    input  logic [csbm_pkg::PAGE_W-1:0]        i_s_axis_tdata,  // [63:0] page_id
    input  logic                               i_s_axis_tuser,  // [0] cmd
    // master stream
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // [3:0] slot_index, [5:4] status, [6] read_needed, [7] zero
    output logic [csbm_pkg::ODATA_W-1:0]       o_m_axis_tdata,
    // configuration
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [2:0]                         paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);

    logic [csbm_pkg::CNT_W-1:0] w_active;
    csbm_pkg::t_dp_cmd          w_cmd;
    csbm_pkg::t_dp_stat         w_stat;

    csbm_cfg u_cfg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .o_active (w_active)
    );

    csbm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    csbm_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_active    (w_active),
        .i_in_cmd    (i_s_axis_tuser),
        .i_in_page   (i_s_axis_tdata),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_out_data  (o_m_axis_tdata)
    );

endmodule
